@@ rtl/tllp_pkg.sv @@
// Shared types, character codes and constants for the timed lyric line parser.
package tllp_pkg;

	// Default width of the saturating text byte counter
	localparam int unsigned TEXT_COUNT_BITS_DEF = 16;

	// Result field widths
	localparam int unsigned TIME_W  = 47;
	localparam int unsigned LEN_W   = 16;
	localparam int unsigned FIELD_W = 31;  // minutes and seconds never exceed FIELD_LIMIT
	localparam int unsigned SEC_MS_W = 41; // seconds * 1000 at the field limit
	localparam int unsigned FRAC_W  = 10;
	localparam int unsigned TDATA_W = 64;

	localparam logic [FIELD_W+3:0] FIELD_LIMIT = 35'd2147483647;
	localparam logic [19:0]        MS_PER_MIN  = 20'd60000;
	localparam logic [19:0]        MS_PER_SEC  = 20'd1000;

	// Character codes
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// Position within the "[m:s.f]" prefix of a line
	typedef enum logic [2:0] {
		PH_START,
		PH_MIN,
		PH_SEC,
		PH_FRAC,
		PH_TEXT
	} phase_t;

	// Weight of a fraction digit by its position: 100, 10, 1
	function automatic logic [6:0] frac_weight(input logic [1:0] pos);
		logic [6:0] w;
		case (pos)
			2'd0:    w = 7'd100;
			2'd1:    w = 7'd10;
			default: w = 7'd1;
		endcase
		return w;
	endfunction

endpackage

@@ rtl/timed_lyric_line_parser_unit.sv @@
// Top level of the timed lyric line parser: byte scanner, time build and result buffer.
//
//  channel   dir  fields (low bit first)                         accepted when
//  s_axis    in   tdata: text_byte[7:0]; tlast: end_of_text     tvalid & tready
//  m_axis    out  tdata: time_ms[46:0], text_length[62:47], 0;  tvalid & tready
//                 tuser: line_ok; tlast: final_line
//
// One byte is taken every cycle while s_axis tready is high. A line-ending byte (newline
// or tlast) delivers its result on m_axis from the output register, via the skid word when stalled.
// A two-word buffer (output register plus skid word) sits at m_axis; s_axis tready
// drops only while the skid word is full, so bytes keep flowing under a short stall.
// Reset (arst_n low) returns the scanner to line start and empties both buffer words.
// The time build keeps minutes and seconds also as running millisecond sums, so a
// line end needs only one three-operand add before the output register.
module timed_lyric_line_parser_unit #(
	parameter int unsigned TEXT_COUNT_BITS = tllp_pkg::TEXT_COUNT_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [7:0]                   s_axis_tdata,  // text_byte[7:0]
	input  logic                         s_axis_tlast,  // end_of_text
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [tllp_pkg::TDATA_W-1:0] m_axis_tdata,  // time_ms[46:0], text_length[62:47], pad
	output logic                         m_axis_tuser,  // line_ok
	output logic                         m_axis_tlast   // final_line
);
	import tllp_pkg::*;

	localparam logic [TEXT_COUNT_BITS-1:0] COUNT_LIMIT = '1;

	// Scanner state
	phase_t                     phase_q, nx_phase;
	logic [FIELD_W-1:0]         min_q, nx_min;
	logic [TIME_W-1:0]          min_ms_q, nx_min_ms;
	logic [FIELD_W-1:0]         sec_q, nx_sec;
	logic [SEC_MS_W-1:0]        sec_ms_q, nx_sec_ms;
	logic [FRAC_W-1:0]          frac_q, nx_frac;
	logic [1:0]                 frac_cnt_q, nx_frac_cnt;
	logic                       seen_q, nx_seen;
	logic                       bad_q, nx_bad;
	logic                       pend_q, nx_pend;
	logic [TEXT_COUNT_BITS-1:0] cnt_q, nx_cnt;

	// Byte decode
	logic       accept;
	logic       is_nl;
	logic       line_end;
	logic       is_dig;
	logic [3:0] dval;

	// Digit arithmetic
	logic [FIELD_W+3:0]  min_ext, sec_ext;
	logic                min_ovf, sec_ovf;
	logic [TIME_W-1:0]   min_ms_step;
	logic [SEC_MS_W-1:0] sec_ms_step;
	logic [FRAC_W-1:0]   frac_step;
	logic [TEXT_COUNT_BITS-1:0] cnt_one, cnt_two;

	// Result of the line that ends with this byte
	logic              res_ok;
	logic [TIME_W-1:0] res_time;
	logic [LEN_W-1:0]  res_len;
	logic [31:0]       cnt_wide;
	logic [TDATA_W-1:0] res_data;

	// Output buffer
	logic               out_valid_q, skid_valid_q;
	logic [TDATA_W-1:0] out_data_q, skid_data_q;
	logic               out_ok_q, skid_ok_q;
	logic               out_last_q, skid_last_q;
	logic               pop, push;

	assign s_axis_tready = !skid_valid_q;
	assign accept   = s_axis_tvalid && s_axis_tready;
	assign is_nl    = (s_axis_tdata == CH_NL);
	assign line_end = is_nl || s_axis_tlast;
	assign is_dig   = (s_axis_tdata >= CH_ZERO) && (s_axis_tdata <= CH_NINE);
	assign dval     = is_dig ? 4'(s_axis_tdata - CH_ZERO) : 4'd0;

	// v*10 + d as shift-adds; fields never exceed FIELD_LIMIT, so 35 bits hold it
	assign min_ext = ({4'd0, min_q} << 3) + ({4'd0, min_q} << 1) + 35'(dval);
	assign sec_ext = ({4'd0, sec_q} << 3) + ({4'd0, sec_q} << 1) + 35'(dval);
	assign min_ovf = min_ext > FIELD_LIMIT;
	assign sec_ovf = sec_ext > FIELD_LIMIT;

	// Running millisecond sums follow the fields digit by digit
	assign min_ms_step = (min_ms_q << 3) + (min_ms_q << 1)
		+ TIME_W'(20'(dval) * MS_PER_MIN);
	assign sec_ms_step = (sec_ms_q << 3) + (sec_ms_q << 1)
		+ SEC_MS_W'(20'(dval) * MS_PER_SEC);
	assign frac_step = frac_q + FRAC_W'(10'(dval) * 10'(frac_weight(frac_cnt_q)));

	// Text count: a held carriage return counts once it proves not to be trailing
	assign cnt_one = (pend_q && cnt_q != COUNT_LIMIT) ? cnt_q + 1'b1 : cnt_q;
	assign cnt_two = (s_axis_tdata != CH_CR && cnt_one != COUNT_LIMIT) ?
		cnt_one + 1'b1 : cnt_one;

	// Next scanner state for one non-newline byte
	always_comb begin
		nx_phase    = phase_q;
		nx_min      = min_q;
		nx_min_ms   = min_ms_q;
		nx_sec      = sec_q;
		nx_sec_ms   = sec_ms_q;
		nx_frac     = frac_q;
		nx_frac_cnt = frac_cnt_q;
		nx_seen     = seen_q;
		nx_bad      = bad_q;
		nx_pend     = pend_q;
		nx_cnt      = cnt_q;
		if (!is_nl && !bad_q) begin
			unique case (phase_q)
				PH_START: begin
					if (s_axis_tdata == CH_LBRACK) begin
						nx_phase = PH_MIN;
						nx_seen  = 1'b0;
					end else begin
						nx_bad = 1'b1;
					end
				end
				PH_MIN: begin
					if (is_dig) begin
						if (min_ovf) begin
							nx_bad = 1'b1;
						end else begin
							nx_min    = min_ext[FIELD_W-1:0];
							nx_min_ms = min_ms_step;
						end
						nx_seen = 1'b1;
					end else if (s_axis_tdata == CH_COLON && seen_q) begin
						nx_phase = PH_SEC;
						nx_seen  = 1'b0;
					end else begin
						nx_bad = 1'b1;
					end
				end
				PH_SEC: begin
					if (is_dig) begin
						if (sec_ovf) begin
							nx_bad = 1'b1;
						end else begin
							nx_sec    = sec_ext[FIELD_W-1:0];
							nx_sec_ms = sec_ms_step;
						end
						nx_seen = 1'b1;
					end else if (s_axis_tdata == CH_DOT && seen_q) begin
						nx_phase = PH_FRAC;
					end else if (s_axis_tdata == CH_RBRACK && seen_q) begin
						nx_phase = PH_TEXT;
					end else begin
						nx_bad = 1'b1;
					end
				end
				PH_FRAC: begin
					if (is_dig) begin
						// drop digits past the third
						if (frac_cnt_q != 2'd3) begin
							nx_frac     = frac_step;
							nx_frac_cnt = frac_cnt_q + 2'd1;
						end
					end else if (s_axis_tdata == CH_RBRACK) begin
						nx_phase = PH_TEXT;
					end else begin
						nx_bad = 1'b1;
					end
				end
				PH_TEXT: begin
					nx_pend = (s_axis_tdata == CH_CR);
					nx_cnt  = cnt_two;
				end
				default: nx_bad = 1'b1;
			endcase
		end
	end

	// Result fields, from the state after this byte
	assign res_ok   = !nx_bad && nx_phase == PH_TEXT && nx_cnt != '0;
	assign cnt_wide = 32'(nx_cnt);
	assign res_time = res_ok ?
		min_ms_q + TIME_W'(sec_ms_q) + TIME_W'(frac_q) : '0;
	assign res_len  = !res_ok ? '0 :
		(cnt_wide > 32'h0000_FFFF) ? 16'hFFFF : cnt_wide[LEN_W-1:0];
	assign res_data = {1'b0, res_len, res_time};

	// Scanner registers; clear to line start after every line end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_START;
			min_q      <= '0;
			min_ms_q   <= '0;
			sec_q      <= '0;
			sec_ms_q   <= '0;
			frac_q     <= '0;
			frac_cnt_q <= '0;
			seen_q     <= 1'b0;
			bad_q      <= 1'b0;
			pend_q     <= 1'b0;
			cnt_q      <= '0;
		end else if (accept) begin
			if (line_end) begin
				phase_q    <= PH_START;
				min_q      <= '0;
				min_ms_q   <= '0;
				sec_q      <= '0;
				sec_ms_q   <= '0;
				frac_q     <= '0;
				frac_cnt_q <= '0;
				seen_q     <= 1'b0;
				bad_q      <= 1'b0;
				pend_q     <= 1'b0;
				cnt_q      <= '0;
			end else begin
				phase_q    <= nx_phase;
				min_q      <= nx_min;
				min_ms_q   <= nx_min_ms;
				sec_q      <= nx_sec;
				sec_ms_q   <= nx_sec_ms;
				frac_q     <= nx_frac;
				frac_cnt_q <= nx_frac_cnt;
				seen_q     <= nx_seen;
				bad_q      <= nx_bad;
				pend_q     <= nx_pend;
				cnt_q      <= nx_cnt;
			end
		end
	end

	// Output register with skid word: hold a new result in the skid word while
	// the output word is stalled, advance it once the output word frees up
	assign pop  = out_valid_q && m_axis_tready;
	assign push = accept && line_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop || !out_valid_q) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !out_valid_q) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
				out_ok_q   <= skid_ok_q;
				out_last_q <= skid_last_q;
			end else begin
				out_data_q <= res_data;
				out_ok_q   <= res_ok;
				out_last_q <= s_axis_tlast;
			end
		end else if (push) begin
			skid_data_q <= res_data;
			skid_ok_q   <= res_ok;
			skid_last_q <= s_axis_tlast;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_ok_q;
	assign m_axis_tlast  = out_last_q;

	// The skid word only fills behind a stalled output word
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word valid without output word");

	// Kept fraction never exceeds three digits
	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		frac_q <= 10'd999 && (frac_q == '0 || frac_cnt_q != 2'd0))
		else $error("fraction accumulator out of range");

	// A rejected line carries zero time and length
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> m_axis_tdata == '0)
		else $error("rejected line with nonzero payload");

	// Every line end returns the scanner to line start
	a_line_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && line_end) |=> (phase_q == PH_START && cnt_q == '0 && !bad_q))
		else $error("scanner not cleared after line end");

	// A line-ending byte always shows up as a valid output word
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> m_axis_tvalid)
		else $error("line result lost");

endmodule

@@ sim/tb_timed_lyric_line_parser_unit.sv @@
// Self-checking testbench for the timed lyric line parser: random LRC text, line predictor.
module tb_timed_lyric_line_parser_unit;
	import tllp_pkg::*;

	localparam int unsigned RANDOM_WORDS = 1740;
	localparam int unsigned LONG_TEXT    = 200;
	localparam int unsigned HOLD_CYCLES  = 400;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
		logic       wait_drain;
	} lyric_word_t;

	typedef struct {
		logic        line_ok;
		logic [46:0] time_ms;
		logic [15:0] text_length;
		logic        final_line;
	} line_result_t;

	typedef enum {END_NL, END_NL_FINAL, END_BYTE_FINAL} line_end_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;

	timed_lyric_line_parser_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #1 clk = ~clk;

	lyric_word_t  byte_feed[$];
	line_result_t expected_lines[$];
	logic [7:0]   line_buf[$];
	line_result_t exp_line;
	lyric_word_t  next_word;
	int unsigned  error_count = 0;
	int unsigned  words_taken = 0;
	bit           took_word = 1'b0;
	int unsigned  burst_left = 0;
	int unsigned  gap_left = 0;
	int unsigned  rx_cycle = 0;
	logic         rx_hold = 1'b0;

	// Line scanner state, cleared at every line end
	phase_t      scan_phase;
	logic [31:0] minutes_acc;
	logic [31:0] seconds_acc;
	logic [9:0]  frac_ms;
	logic [1:0]  frac_cnt;
	logic        seen_digit;
	logic        bad_line;
	logic        cr_held;
	logic [15:0] text_cnt;

	task automatic clear_scan();
		scan_phase  = PH_START;
		minutes_acc = '0;
		seconds_acc = '0;
		frac_ms     = '0;
		frac_cnt    = '0;
		seen_digit  = 1'b0;
		bad_line    = 1'b0;
		cr_held     = 1'b0;
		text_cnt    = '0;
	endtask

	// Shift one decimal digit into a timestamp field; reject the line on overflow
	task automatic shift_digit(inout logic [31:0] acc, input logic [7:0] b);
		logic [35:0] n;
		n = 36'(acc) * 36'd10 + 36'(b - CH_ZERO);
		if (n > 36'(FIELD_LIMIT))
			bad_line = 1'b1;
		else
			acc = n[31:0];
	endtask

	task automatic bump_text();
		if (text_cnt != 16'hFFFF)
			text_cnt++;
	endtask

	task automatic scan_byte(input logic [7:0] b);
		logic is_digit;
		is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
		if (!bad_line) begin
			case (scan_phase)
				PH_START: begin
					if (b == CH_LBRACK) begin
						scan_phase = PH_MIN;
						seen_digit = 1'b0;
					end else
						bad_line = 1'b1;
				end
				PH_MIN: begin
					if (is_digit) begin
						shift_digit(minutes_acc, b);
						seen_digit = 1'b1;
					end else if (b == CH_COLON && seen_digit) begin
						scan_phase = PH_SEC;
						seen_digit = 1'b0;
					end else
						bad_line = 1'b1;
				end
				PH_SEC: begin
					if (is_digit) begin
						shift_digit(seconds_acc, b);
						seen_digit = 1'b1;
					end else if (b == CH_DOT && seen_digit)
						scan_phase = PH_FRAC;
					else if (b == CH_RBRACK && seen_digit)
						scan_phase = PH_TEXT;
					else
						bad_line = 1'b1;
				end
				PH_FRAC: begin
					if (is_digit) begin
						// keep the first three digits as milliseconds, truncate the rest
						if (frac_cnt == 2'd0)
							frac_ms = frac_ms + 10'(b - CH_ZERO) * 10'd100;
						else if (frac_cnt == 2'd1)
							frac_ms = frac_ms + 10'(b - CH_ZERO) * 10'd10;
						else if (frac_cnt == 2'd2)
							frac_ms = frac_ms + 10'(b - CH_ZERO);
						if (frac_cnt != 2'd3)
							frac_cnt++;
					end else if (b == CH_RBRACK)
						scan_phase = PH_TEXT;
					else
						bad_line = 1'b1;
				end
				PH_TEXT: begin
					// a held carriage return counts once another byte follows it
					if (cr_held)
						bump_text();
					if (b == CH_CR)
						cr_held = 1'b1;
					else begin
						cr_held = 1'b0;
						bump_text();
					end
				end
				default: bad_line = 1'b1;
			endcase
		end
	endtask

	task automatic predict_word(input logic [7:0] b, input logic eot);
		line_result_t r;
		if (b != CH_NL)
			scan_byte(b);
		if (b == CH_NL || eot) begin
			r.line_ok     = !bad_line && scan_phase == PH_TEXT && text_cnt != 16'd0;
			r.time_ms     = '0;
			r.text_length = '0;
			r.final_line  = eot;
			if (r.line_ok) begin
				r.time_ms = 47'(minutes_acc) * 47'd60000 + 47'(seconds_acc) * 47'd1000
					+ 47'(frac_ms);
				r.text_length = text_cnt;
			end
			expected_lines.insert(expected_lines.size(), r);
			clear_scan();
		end
	endtask

	// ---- stimulus builders ----

	function automatic logic [7:0] any_text_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CH_NL);
		return b;
	endfunction

	function automatic longint unsigned pick_field();
		longint unsigned v;
		case ($urandom_range(0, 9))
			0:       v = 64'd2147483647 - $urandom_range(0, 3);
			1:       v = 64'd2147483648 + $urandom_range(0, 3);
			2:       v = (longint'($urandom) << 3) % 64'd10000000000;
			3:       v = $urandom_range(0, 99999);
			default: v = $urandom_range(0, 99);
		endcase
		return v;
	endfunction

	// Append one byte to the line under construction
	task automatic add_byte(input logic [7:0] b);
		line_buf.insert(line_buf.size(), b);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	task automatic add_number(input longint unsigned v, input int unsigned zeros);
		logic [7:0] digits[$];
		repeat (zeros)
			add_byte(CH_ZERO);
		do begin
			digits.push_front(CH_ZERO + 8'(v % 10));
			v = v / 10;
		end while (v != 0);
		foreach (digits[i])
			add_byte(digits[i]);
	endtask

	task automatic build_timed_line();
		int unsigned n;
		add_byte(CH_LBRACK);
		add_number(pick_field(), ($urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0);
		add_byte(CH_COLON);
		add_number(pick_field(), ($urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0);
		if ($urandom_range(0, 2) != 0) begin
			add_byte(CH_DOT);
			n = $urandom_range(0, 5);
			repeat (n)
				add_byte(CH_ZERO + 8'($urandom_range(0, 9)));
		end
		add_byte(CH_RBRACK);
		n = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 10);
		repeat (n)
			add_byte(($urandom_range(0, 7) == 0) ? CH_CR : any_text_byte());
		if ($urandom_range(0, 3) == 0)
			add_byte(CH_CR);
	endtask

	// Damage one spot of the line: replace, drop or insert a byte
	task automatic break_line();
		logic [7:0] trouble[6];
		int unsigned pos;
		logic [7:0] b;
		trouble = '{8'h2D, 8'h2B, 8'h20, CH_DOT, CH_COLON, CH_LBRACK};
		pos = $urandom_range(0, line_buf.size() - 1);
		b = ($urandom_range(0, 1) == 0) ? trouble[$urandom_range(0, 5)] : any_text_byte();
		case ($urandom_range(0, 2))
			0:       line_buf[pos] = b;
			1:       line_buf.delete(pos);
			default: line_buf.insert(pos, b);
		endcase
	endtask

	task automatic build_noise();
		int unsigned n;
		n = $urandom_range(0, 12);
		repeat (n)
			add_byte(any_text_byte());
	endtask

	task automatic emit_line(input line_end_t how, input bit drain);
		lyric_word_t w;
		if (how != END_BYTE_FINAL || line_buf.size() == 0)
			add_byte(CH_NL);
		foreach (line_buf[i]) begin
			w.text_byte   = line_buf[i];
			w.end_of_text = (how != END_NL) && (i == line_buf.size() - 1);
			w.wait_drain  = drain && (i == 0);
			byte_feed.insert(byte_feed.size(), w);
		end
		line_buf.delete();
	endtask

	// ---- sender: bursts of random length, random gaps ----
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || took_word) begin
				took_word = 1'b0;
				if (gap_left != 0 || byte_feed.size() == 0
						|| (byte_feed[0].wait_drain && expected_lines.size() != 0)) begin
					s_axis_tvalid <= 1'b0;
					if (gap_left != 0)
						gap_left--;
				end else begin
					next_word = byte_feed.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= next_word.text_byte;
					s_axis_tlast  <= next_word.end_of_text;
					if (burst_left <= 1) begin
						burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
					end else
						burst_left--;
				end
			end
		end
	end

	// ---- receiver: stall pattern steps through four modes chosen by rx_cycle ----
	always @(negedge clk) begin
		if (arst_n) begin
			rx_cycle++;
			case (rx_cycle[8:7])
				2'd0:    m_axis_tready <= !rx_hold;
				2'd1:    m_axis_tready <= !rx_hold && ($urandom_range(0, 1) == 1);
				2'd2:    m_axis_tready <= !rx_hold && (rx_cycle[1:0] == 2'd0);
				default: m_axis_tready <= !rx_hold && ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// Hold the receiver off for a long stretch once 400 input words have been taken
	initial begin
		while (words_taken < 400)
			@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES)
			@(posedge clk);
		rx_hold <= 1'b0;
	end

	// ---- monitor: predict on every input word, check every output word ----
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_word(s_axis_tdata, s_axis_tlast);
				words_taken++;
				took_word = 1'b1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_lines.size() == 0) begin
					$error("result word with no line pending: tdata=%h tuser=%b tlast=%b",
						m_axis_tdata, m_axis_tuser, m_axis_tlast);
					error_count++;
				end else begin
					exp_line = expected_lines.pop_front();
					if (m_axis_tuser !== exp_line.line_ok) begin
						$error("line_ok: expected %0d, got %0d", exp_line.line_ok, m_axis_tuser);
						error_count++;
					end
					if (m_axis_tdata[46:0] !== exp_line.time_ms) begin
						$error("time_ms: expected %0d, got %0d", exp_line.time_ms,
							m_axis_tdata[46:0]);
						error_count++;
					end
					if (m_axis_tdata[62:47] !== exp_line.text_length) begin
						$error("text_length: expected %0d, got %0d", exp_line.text_length,
							m_axis_tdata[62:47]);
						error_count++;
					end
					if (m_axis_tlast !== exp_line.final_line) begin
						$error("final_line: expected %0d, got %0d", exp_line.final_line,
							m_axis_tlast);
						error_count++;
					end
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int unsigned n_lines;
		int unsigned pick;
		clear_scan();

		// directed: minimal line, stamp with a three-digit fraction and kept and dropped carriage
		// return, then empty text ending the text on the closing bracket
		push_text("[0:0]a");
		emit_line(END_NL, 1'b0);
		push_text("[99:59.999]");
		add_byte(8'hFF);
		add_byte(CH_CR);
		add_byte(CH_CR);
		emit_line(END_NL, 1'b0);
		push_text("[9:1.5]");
		emit_line(END_BYTE_FINAL, 1'b0);

		// random documents of a few lines each
		while (byte_feed.size() < RANDOM_WORDS) begin
			n_lines = $urandom_range(1, 6);
			for (int k = 0; k < n_lines; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 72)
					build_timed_line();
				else if (pick < 88) begin
					build_timed_line();
					break_line();
				end else
					build_noise();
				if (k != n_lines - 1)
					emit_line(END_NL, $urandom_range(0, 39) == 0);
				else if ($urandom_range(0, 1) == 1 && line_buf.size() != 0)
					emit_line(END_BYTE_FINAL, $urandom_range(0, 39) == 0);
				else
					emit_line(END_NL_FINAL, $urandom_range(0, 39) == 0);
			end
		end

		// one line with a long run of text
		push_text("[1:2.3]");
		repeat (LONG_TEXT)
			add_byte(any_text_byte());
		emit_line(END_NL_FINAL, 1'b1);
		push_text("[0:1]z");
		emit_line(END_NL_FINAL, 1'b1);

		repeat (5)
			@(negedge clk);
		arst_n <= 1'b1;

		while (byte_feed.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (expected_lines.size() != 0)
			@(negedge clk);
		repeat (10)
			@(negedge clk);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ files.f @@
rtl/tllp_pkg.sv
rtl/timed_lyric_line_parser_unit.sv
sim/tb_timed_lyric_line_parser_unit.sv
